@@ rtl/wsfd_pkg.sv @@
// wsfd_pkg: shared types and constants of the websocket frame deframer
// holds the parser phase enum, result kind codes and the command struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

	// command queue between parser front and result back
	localparam int unsigned CQ_DEPTH = 4;
	localparam int unsigned CQ_AW    = $clog2(CQ_DEPTH);

	// header field codes
	localparam logic [3:0] OP_CLOSE   = 4'h8;
	localparam logic [3:0] OP_TEXT    = 4'h1;
	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;

	// header byte counts; eight bytes is held as zero, wrapping on decrement
	localparam logic [2:0] EXT16_BYTES = 3'd2;
	localparam logic [2:0] EXT64_BYTES = 3'd0;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd4095;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_HDR1_CLOSE,
		PH_EXTLEN,
		PH_MASK,
		PH_PAYLOAD,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_CLOSE    = 2'd2,
		KIND_OVERSIZE = 2'd3
	} kind_t;

	// one classified item from the front, still masked
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] key;
		logic       text;
		logic       last;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/wsfd_front.sv @@
// wsfd_front: frame header walker; classifies each received byte
// emits at most one command per accepted byte into the command queue
// depends on wsfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsfd_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [7:0]       stream_byte,
	input  wire logic [15:0]      max_payload,
	input  wire logic             cmd_full,
	output logic                  cmd_push,
	output wsfd_pkg::cmd_t        cmd
);
	import wsfd_pkg::*;

	phase_t      phase_q, phase_d;
	logic        text_q;
	logic        masked_q;
	logic [15:0] len_q;
	logic        hi_q;
	logic [2:0]  cnt_q;
	logic [31:0] key_q;
	logic [1:0]  idx_q;

	logic        fire;
	logic [6:0]  len7;
	logic        len_ext;
	logic [2:0]  cnt_dec;
	logic        cnt_end;
	logic [15:0] ext_len_nxt;
	logic        ext_hi_nxt;
	logic        hdr_chk;
	logic [15:0] chk_len;
	logic        chk_hi;
	logic        oversize;
	logic        zero_len;
	phase_t      hdr_end_ph;
	logic [7:0]  key_byte;

	// byte accept and header decode helpers
	assign fire        = push && !cmd_full;
	assign len7        = stream_byte[6:0];
	assign len_ext     = (len7 == LEN16_CODE) || (len7 == LEN64_CODE);
	assign cnt_dec     = cnt_q - 3'd1;
	assign cnt_end     = (cnt_dec == 3'd0);
	assign ext_len_nxt = {len_q[7:0], stream_byte};
	assign ext_hi_nxt  = hi_q || (len_q[15:8] != 8'd0);

	// header complete on this byte: length is known and checked
	always_comb begin
		hdr_chk = 1'b0;
		chk_len = len_q;
		chk_hi  = hi_q;
		if (phase_q == PH_HDR1) begin
			hdr_chk = !len_ext && !stream_byte[7];
			chk_len = {9'd0, len7};
			chk_hi  = 1'b0;
		end else if (phase_q == PH_EXTLEN) begin
			hdr_chk = cnt_end && !masked_q;
			chk_len = ext_len_nxt;
			chk_hi  = ext_hi_nxt;
		end else if (phase_q == PH_MASK) begin
			hdr_chk = cnt_end;
		end
	end

	assign oversize = chk_hi || (chk_len > max_payload);
	assign zero_len = !chk_hi && (chk_len == 16'd0);

	always_comb begin
		if (oversize) begin
			hdr_end_ph = PH_HALT;
		end else if (zero_len) begin
			hdr_end_ph = PH_HDR0;
		end else begin
			hdr_end_ph = PH_PAYLOAD;
		end
	end

	// mask key byte for the current payload position
	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			unique case (phase_q)
				PH_HDR0: begin
					phase_d = (stream_byte[3:0] == OP_CLOSE) ? PH_HDR1_CLOSE : PH_HDR1;
				end
				PH_HDR1_CLOSE: begin
					phase_d = PH_HALT;
				end
				PH_HDR1: begin
					if (len_ext) begin
						phase_d = PH_EXTLEN;
					end else if (stream_byte[7]) begin
						phase_d = PH_MASK;
					end else begin
						phase_d = hdr_end_ph;
					end
				end
				PH_EXTLEN: begin
					if (cnt_end) begin
						phase_d = masked_q ? PH_MASK : hdr_end_ph;
					end
				end
				PH_MASK: begin
					if (cnt_end) begin
						phase_d = hdr_end_ph;
					end
				end
				PH_PAYLOAD: begin
					if (len_q == 16'd1) begin
						phase_d = PH_HDR0;
					end
				end
				PH_HALT: begin
					phase_d = PH_HALT;
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
		end
	end

	// command for the back end
	always_comb begin
		cmd_push  = 1'b0;
		cmd.kind  = KIND_PAYLOAD;
		cmd.data  = 8'd0;
		cmd.key   = 8'd0;
		cmd.text  = text_q;
		cmd.last  = 1'b0;
		if (fire) begin
			unique case (phase_q) inside
				PH_HDR1_CLOSE: begin
					cmd_push = 1'b1;
					cmd.kind = KIND_CLOSE;
					cmd.text = 1'b0;
				end
				PH_PAYLOAD: begin
					cmd_push = 1'b1;
					cmd.data = stream_byte;
					cmd.key  = masked_q ? key_byte : 8'd0;
					cmd.last = (len_q == 16'd1);
				end
				PH_HDR1, PH_EXTLEN, PH_MASK: begin
					if (hdr_chk && oversize) begin
						cmd_push = 1'b1;
						cmd.kind = KIND_OVERSIZE;
					end else if (hdr_chk && zero_len) begin
						cmd_push = 1'b1;
						cmd.kind = KIND_EMPTY;
					end
				end
				default: begin
					cmd_push = 1'b0;
				end
			endcase
		end
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
		end else begin
			phase_q <= phase_d;
		end
	end

	// header fields, length counter and mask key
	always_ff @(posedge clk) begin
		if (fire) begin
			case (phase_q)
				PH_HDR0: begin
					if (stream_byte[3:0] != OP_CLOSE) begin
						text_q <= (stream_byte[3:0] == OP_TEXT);
					end
				end
				PH_HDR1: begin
					masked_q <= stream_byte[7];
					hi_q     <= 1'b0;
					if (len7 == LEN16_CODE) begin
						cnt_q <= EXT16_BYTES;
						len_q <= 16'd0;
					end else if (len7 == LEN64_CODE) begin
						cnt_q <= EXT64_BYTES;
						len_q <= 16'd0;
					end else begin
						cnt_q <= KEY_BYTES;
						len_q <= {9'd0, len7};
					end
				end
				PH_EXTLEN: begin
					len_q <= ext_len_nxt;
					hi_q  <= ext_hi_nxt;
					cnt_q <= (cnt_end && masked_q) ? KEY_BYTES : cnt_dec;
				end
				PH_MASK: begin
					key_q <= {key_q[23:0], stream_byte};
					cnt_q <= cnt_dec;
				end
				PH_PAYLOAD: begin
					idx_q <= idx_q + 2'd1;
					len_q <= len_q - 16'd1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
			if (hdr_chk) begin
				idx_q <= 2'd0;
			end
		end
	end

	// a halted parser never resumes before reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("parser left halt");

	// commands only come from an accepted byte
	a_cmd_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (push && !cmd_full))
		else $error("command without accepted byte");

	// payload phase always has a nonzero, in-range byte count
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> (len_q != 16'd0 && !hi_q))
		else $error("payload phase with empty length");

endmodule

`default_nettype wire

@@ rtl/wsfd_cmdq.sv @@
// wsfd_cmdq: short command queue between parser front and result back
// register array with read and write pointers and a fill count
// depends on wsfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsfd_cmdq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wsfd_pkg::cmd_t        wr_cmd,
	output logic                  full,
	input  wire logic             rd,
	output wsfd_pkg::cmd_t        rd_cmd,
	output logic                  empty
);
	import wsfd_pkg::*;

	cmd_t             slot_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wptr_q;
	logic [CQ_AW-1:0] rptr_q;
	logic [CQ_AW:0]   count_q;

	localparam logic [CQ_AW:0] DEPTH_CNT = (CQ_AW+1)'(CQ_DEPTH);

	assign full   = (count_q == DEPTH_CNT);
	assign empty  = (count_q == '0);
	assign rd_cmd = slot_q[rptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + CQ_AW'(1);
			end
			if (rd) begin
				rptr_q <= rptr_q + CQ_AW'(1);
			end
			count_q <= count_q + (CQ_AW+1)'(wr) - (CQ_AW+1)'(rd);
		end
	end

	// the front must hold off while the queue is full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full))
		else $error("command queue overflow");

	// the back must not take from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd && empty))
		else $error("command queue underflow");

endmodule

`default_nettype wire

@@ rtl/wsfd_back.sv @@
// wsfd_back: result stage; unmasks payload bytes and holds the result register
// takes commands from the queue whenever the result register frees up
// depends on wsfd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsfd_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_empty,
	input  wsfd_pkg::cmd_t        cmd,
	output logic                  cmd_pop,
	input  wire logic             pop,
	output logic                  empty,
	output logic [1:0]            kind,
	output logic [7:0]            payload_byte,
	output logic                  text_frame,
	output logic                  last_byte
);
	import wsfd_pkg::*;

	logic       valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       text_q;
	logic       last_q;

	// refill when the register is free or being taken
	assign cmd_pop = !cmd_empty && (!valid_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// unmask on load
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			kind_q <= cmd.kind;
			byte_q <= cmd.data ^ cmd.key;
			text_q <= cmd.text;
			last_q <= cmd.last;
		end
	end

	assign empty        = !valid_q;
	assign kind         = kind_q;
	assign payload_byte = byte_q;
	assign text_frame   = text_q;
	assign last_byte    = last_q;

endmodule

`default_nettype wire

@@ rtl/websocket_frame_deframer_unit.sv @@
// websocket_frame_deframer_unit: top level of the websocket frame deframer
// parser front, command queue and result back; max_payload register
// depends on wsfd_pkg, wsfd_front, wsfd_cmdq, wsfd_back
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------------
//  input    | push / full             | stream_byte
//  result   | pop / empty             | kind, payload_byte, text_frame, last_byte
//  config   | cfg_valid / cfg_ready   | cfg_max_payload
//
// one byte is taken per cycle while full is low; the header walker updates its registered state on each accepted byte
// a result passes through the command queue and then the result register before it reaches the result ports
// full rises only when the four-entry command queue is full (result side stalled)
// a close frame or an oversize length halts parsing until arst_n is asserted
// cfg_ready is always high; max_payload resets to 4095
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  stream_byte,
	input  wire logic        pop,
	output logic             empty,
	output logic [1:0]       kind,
	output logic [7:0]       payload_byte,
	output logic             text_frame,
	output logic             last_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_max_payload
);
	import wsfd_pkg::*;

	logic [15:0] max_payload_q;
	logic        cmd_push;
	cmd_t        cmd_in;
	logic        cmd_full;
	logic        cmd_pop;
	cmd_t        cmd_out;
	logic        cmd_empty;

	// size limit register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_payload_q <= cfg_max_payload;
		end
	end

	assign full = cmd_full;

	wsfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.stream_byte (stream_byte),
		.max_payload (max_payload_q),
		.cmd_full    (cmd_full),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	wsfd_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wr_cmd (cmd_in),
		.full   (cmd_full),
		.rd     (cmd_pop),
		.rd_cmd (cmd_out),
		.empty  (cmd_empty)
	);

	wsfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_empty    (cmd_empty),
		.cmd          (cmd_out),
		.cmd_pop      (cmd_pop),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.payload_byte (payload_byte),
		.text_frame   (text_frame),
		.last_byte    (last_byte)
	);

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking bench for websocket_frame_deframer_unit, byte-stream frames in, results out
// holds a frame predictor, a bursty byte driver, a stalling result monitor and register phases
// depends on wsfd_pkg and websocket_frame_deframer_unit
`timescale 1ns / 1ps

module tb;
	import wsfd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned REPORT_CAP  = 20;

	typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       text;
		logic       last;
	} deframed_t;

	logic        clk;
	logic        arst_n          = 1'b0;
	logic        push            = 1'b0;
	logic [7:0]  stream_byte     = 8'h00;
	logic        pop             = 1'b0;
	logic        cfg_valid       = 1'b0;
	logic [15:0] cfg_max_payload = 16'h0000;
	logic        full, empty, cfg_ready, text_frame, last_byte;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;

	// frame walker state, mirrors the block
	phase_t      walk_phase = PH_HDR0;
	logic        walk_text  = 1'b0;
	logic        walk_mask  = 1'b0;
	logic [63:0] walk_left  = '0;
	logic [2:0]  walk_count = '0;
	logic [31:0] walk_key   = '0;
	logic [1:0]  walk_pos   = '0;
	logic        walk_halt  = 1'b0;
	logic [15:0] size_limit = MAX_PAYLOAD_RST;

	logic [7:0]  pending_bytes[$];
	deframed_t   due_results[$];
	int unsigned queued_total   = 0;
	int unsigned accepted_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	int unsigned burst_left  = 0;
	int unsigned gap_left    = 0;
	logic [15:0] pop_pattern = 16'hFFFF;
	int unsigned pattern_age = 0;
	int unsigned hold_left   = 0;
	int unsigned holds_done  = 0;

	websocket_frame_deframer_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.stream_byte     (stream_byte),
		.pop             (pop),
		.empty           (empty),
		.kind            (kind),
		.payload_byte    (payload_byte),
		.text_frame      (text_frame),
		.last_byte       (last_byte),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_max_payload (cfg_max_payload)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (mismatch_count < REPORT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	task automatic add_due(input kind_t k, input logic [7:0] d, input logic t, input logic l);
		due_results.push_back('{k, d, t, l});
	endtask

	// length and key complete: size check, then payload or empty frame
	task automatic check_length();
		if (walk_left > 64'(size_limit)) begin
			add_due(KIND_OVERSIZE, 8'h00, walk_text, 1'b0);
			walk_halt = 1'b1;
		end else if (walk_left == 0) begin
			add_due(KIND_EMPTY, 8'h00, walk_text, 1'b0);
			walk_phase = PH_HDR0;
		end else begin
			walk_pos   = '0;
			walk_phase = PH_PAYLOAD;
		end
	endtask

	// length complete: mask key next when masked
	task automatic finish_length();
		if (walk_mask) begin
			walk_count = KEY_BYTES;
			walk_key   = '0;
			walk_phase = PH_MASK;
		end else begin
			check_length();
		end
	endtask

	// one accepted byte through the frame walker
	task automatic walk_frame_byte(input logic [7:0] b);
		logic [7:0] v;
		if (walk_halt)
			return;
		case (walk_phase)
			PH_HDR1_CLOSE: begin
				add_due(KIND_CLOSE, 8'h00, 1'b0, 1'b0);
				walk_halt = 1'b1;
			end
			PH_HDR1: begin
				walk_mask = b[7];
				walk_left = '0;
				if (b[6:0] == LEN16_CODE) begin
					walk_count = EXT16_BYTES;
					walk_phase = PH_EXTLEN;
				end else if (b[6:0] == LEN64_CODE) begin
					walk_count = EXT64_BYTES;
					walk_phase = PH_EXTLEN;
				end else begin
					walk_left = 64'(b[6:0]);
					finish_length();
				end
			end
			PH_EXTLEN: begin
				walk_left  = {walk_left[55:0], b};
				walk_count = walk_count - 3'd1;
				if (walk_count == 0)
					finish_length();
			end
			PH_MASK: begin
				walk_key   = {walk_key[23:0], b};
				walk_count = walk_count - 3'd1;
				if (walk_count == 0)
					check_length();
			end
			PH_PAYLOAD: begin
				v = b;
				if (walk_mask)
					v = v ^ walk_key[8 * (3 - int'(walk_pos)) +: 8];
				walk_pos  = walk_pos + 2'd1;
				walk_left = walk_left - 64'd1;
				add_due(KIND_PAYLOAD, v, walk_text, walk_left == 0);
				if (walk_left == 0)
					walk_phase = PH_HDR0;
			end
			default: begin
				if (b[3:0] == OP_CLOSE) begin
					walk_phase = PH_HDR1_CLOSE;
				end else begin
					walk_text  = (b[3:0] == OP_TEXT);
					walk_phase = PH_HDR1;
				end
			end
		endcase
	endtask

	// stimulus building
	task automatic queue_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		queued_total++;
	endtask

	// header, optional key and random payload; the length field need not match the payload
	task automatic queue_frame(input logic [3:0] op, input logic masked, input logic [63:0] len,
	                           input len_form_t form, input int unsigned n_payload);
		queue_byte({4'($urandom_range(0, 15)), op});
		case (form)
			LEN_SHORT: begin
				queue_byte({masked, len[6:0]});
			end
			LEN_EXT16: begin
				queue_byte({masked, LEN16_CODE});
				queue_byte(len[15:8]);
				queue_byte(len[7:0]);
			end
			default: begin
				queue_byte({masked, LEN64_CODE});
				for (int i = 7; i >= 0; i--)
					queue_byte(len[8 * i +: 8]);
			end
		endcase
		if (masked)
			repeat (4) queue_byte(8'($urandom));
		repeat (n_payload) queue_byte(8'($urandom));
	endtask

	// well-formed frame within the limit, mostly short
	task automatic random_frame(input int unsigned limit);
		int unsigned cap;
		int unsigned len;
		int unsigned pick;
		logic [3:0]  op;
		len_form_t   form;
		op = 4'($urandom_range(0, 15));
		if (op == OP_CLOSE || $urandom_range(0, 2) == 0)
			op = OP_TEXT;
		pick = $urandom_range(0, 99);
		cap  = (pick < 70) ? 12 : (pick < 92) ? 40 : 300;
		if (cap > limit)
			cap = limit;
		len  = $urandom_range(0, cap);
		pick = $urandom_range(0, 9);
		if (len > 125 || pick >= 7)
			form = (pick == 9) ? LEN_EXT64 : LEN_EXT16;
		else
			form = LEN_SHORT;
		queue_frame(op, 1'($urandom), 64'(len), form, len);
	endtask

	task automatic fill_frames(input int unsigned budget);
		int unsigned start;
		start = queued_total;
		while (queued_total - start < budget)
			random_frame(size_limit);
	endtask

	// everything sent and drained, then wait for the pipeline to settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_bytes.size() != 0 || push || due_results.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		cfg_valid       <= 1'b1;
		cfg_max_payload <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid  <= 1'b0;
		size_limit = v;
	endtask

	// byte driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push       <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!push || !full) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				push     <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				push        <= 1'b1;
				stream_byte <= pending_bytes.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 32);
					gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// result monitor: checks results, then predicts from the byte taken at the same edge
	always @(posedge clk or negedge arst_n) begin
		deframed_t want;
		if (!arst_n) begin
			pop         <= 1'b0;
			pop_pattern <= 16'hFFFF;
			pattern_age <= 0;
			walk_phase  = PH_HDR0;
			walk_text   = 1'b0;
			walk_mask   = 1'b0;
			walk_left   = '0;
			walk_count  = '0;
			walk_key    = '0;
			walk_pos    = '0;
			walk_halt   = 1'b0;
		end else begin
			if (pop && !empty) begin
				if (due_results.size() == 0) begin
					report_mismatch($sformatf("result kind %0d with nothing due", kind));
				end else begin
					want = due_results.pop_front();
					if (kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
					if (payload_byte !== want.data)
						report_mismatch($sformatf("payload_byte %h, expected %h",
							payload_byte, want.data));
					if (text_frame !== want.text)
						report_mismatch($sformatf("text_frame %b, expected %b",
							text_frame, want.text));
					if (last_byte !== want.last)
						report_mismatch($sformatf("last_byte %b, expected %b",
							last_byte, want.last));
				end
			end
			if (push && !full) begin
				accepted_count <= accepted_count + 1;
				walk_frame_byte(stream_byte);
			end
			// stall pattern, rotated each cycle and renewed now and then
			if (pattern_age == 47) begin
				pattern_age <= 0;
				pop_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
			end else begin
				pattern_age <= pattern_age + 1;
				pop_pattern <= {pop_pattern[0], pop_pattern[15:1]};
			end
			pop <= (hold_left == 0) && pop_pattern[0];
		end
	end

	// long receiver hold-offs so the block fills and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left  <= 0;
			holds_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if ((holds_done == 0 && accepted_count >= 120) ||
		             (holds_done == 1 && accepted_count >= 650)) begin
			hold_left  <= 80;
			holds_done <= holds_done + 1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("websocket_frame_deframer_unit test failed");
			$finish;
		end
	end

	initial begin
		int unsigned pick;
		logic [63:0] len;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames at the reset limit
		@(negedge clk);
		queue_frame(OP_TEXT, 1'b1, 64'd1, LEN_SHORT, 0);
		queue_byte(8'hFF);
		queue_frame(4'hA, 1'b1, 64'd0, LEN_SHORT, 0);
		queue_frame(4'h2, 1'b0, 64'd0, LEN_EXT16, 0);
		queue_frame(4'h0, 1'b0, 64'd1, LEN_EXT64, 0);
		queue_byte(8'h00);
		wait_idle();

		// widest limit, some long frames
		write_limit(16'hFFFF);
		@(negedge clk);
		fill_frames(450);
		wait_idle();

		// zero limit, empty frames only
		write_limit(16'h0000);
		@(negedge clk);
		fill_frames(150);
		wait_idle();

		// small random limit, one frame exactly at it
		write_limit(16'($urandom_range(1, 150)));
		@(negedge clk);
		queue_frame(OP_TEXT, 1'b1, 64'(size_limit), LEN_EXT16, size_limit);
		fill_frames(450);
		wait_idle();

		// closing frame or oversize length, then bytes that must be dropped
		@(negedge clk);
		if ($urandom_range(0, 1) == 0) begin
			queue_byte({4'($urandom_range(0, 15)), OP_CLOSE});
			queue_byte(8'($urandom));
		end else begin
			pick = $urandom_range(0, 2);
			if (pick == 0 && size_limit < 125) begin
				queue_frame(OP_TEXT, 1'($urandom),
					64'($urandom_range(size_limit + 1, 125)), LEN_SHORT, 0);
			end else if (pick == 1) begin
				queue_frame(4'h2, 1'($urandom),
					64'($urandom_range(size_limit + 1, 65535)), LEN_EXT16, 0);
			end else begin
				len = {32'($urandom), 32'($urandom)};
				if (len <= 64'(size_limit))
					len[63] = 1'b1;
				queue_frame(OP_TEXT, 1'($urandom), len, LEN_EXT64, 0);
			end
		end
		repeat (24) queue_byte(8'($urandom));
		wait_idle();

		if (mismatch_count == 0)
			$display("websocket_frame_deframer_unit test passed");
		else
			$display("websocket_frame_deframer_unit test failed");
		$finish;
	end

endmodule
